[sv/rasp_pkg.sv]
package rasp_pkg;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2
    } phase_t;

    localparam logic [1:0] KIND_VALUE  = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [1:0] END_OK        = 2'd0;
    localparam logic [1:0] END_TRUNC_HDR = 2'd1;
    localparam logic [1:0] END_TRUNC_VAL = 2'd2;

    // bit 0 value, bit 1 commit, bit 2 end; emitted lowest bit first
    localparam int unsigned RES_VALUE  = 0;
    localparam int unsigned RES_COMMIT = 1;
    localparam int unsigned RES_END    = 2;

    // everything one input byte produces, minus the pending-result mask
    typedef struct packed {
        logic [7:0] sub_type;
        logic [7:0] value_byte;
        logic [7:0] byte_index;
        logic [7:0] sub_length;
        logic [7:0] end_type;
        logic [7:0] end_length;
        logic [1:0] end_status;
    } bundle_t;

endpackage

[sv/rasp_in_if.sv]
interface rasp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[sv/rasp_out_if.sv]
interface rasp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] sub_type;
    logic [7:0] value_byte;
    logic [7:0] byte_index;
    logic [7:0] sub_length;
    logic [1:0] end_status;
    logic       run_last;

    modport source (output valid, output kind, output sub_type, output value_byte,
                    output byte_index, output sub_length, output end_status,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input sub_type, input value_byte,
                    input byte_index, input sub_length, input end_status,
                    input run_last, output ready);
endinterface

[sv/relay_agent_suboption_parser.sv]
// Relay agent information option sub-option parser.
// option_bytes: one raw option byte per word, last_byte marks the final byte
// of the option data. results: one word per parsed event; kind 0 is a value
// byte, kind 1 closes a complete sub-option, kind 2 ends the option data with
// a status (ok, truncated header, truncated value). run_last marks the final
// word caused by one input byte. A byte causes zero to three words.
// The parse state updates in the cycle a byte is accepted; its words go into
// a two-slot result buffer and are shown from that registered buffer.
// While results.ready is high the output drains one word per cycle, so a
// byte is taken every cycle as long as bytes average at most one word each.
// option_bytes.ready drops only when both buffer slots hold undelivered
// words, so a stalled receiver backs up into the input after two producing
// bytes and nothing is lost.
// Reset clears the parse state (expect a type byte) and empties the buffer.
// After an end word the parser is back at its reset state for the next
// option.
module relay_agent_suboption_parser (
    input  logic         clk,
    input  logic         rst_n,
    rasp_in_if.sink      option_bytes,
    rasp_out_if.source   results
);
    import rasp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_type_reg, held_type_next;
    logic [7:0] held_length_reg, held_length_next;
    logic [7:0] value_count_reg, value_count_next;

    logic [2:0] mask_reg [2];
    logic [2:0] mask_next [2];
    bundle_t    slot_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;

    logic       accept;
    logic       push;
    logic       pop;
    logic       pop_done;
    logic       tail;
    logic [2:0] new_mask;
    bundle_t    new_bundle;
    logic [7:0] count_inc;
    logic [2:0] head_mask;
    logic [2:0] low_bit;
    logic [2:0] head_mask_left;
    bundle_t    head_bundle;

    assign accept = option_bytes.valid && option_bytes.ready;
    assign option_bytes.ready = (count_reg != 2'd2);

    // parse step
    always_comb
    begin
        phase_next       = phase_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        value_count_next = value_count_reg;
        new_mask         = 3'b000;
        count_inc        = value_count_reg + 8'd1;

        new_bundle.sub_type   = held_type_reg;
        new_bundle.value_byte = option_bytes.data_byte;
        new_bundle.byte_index = value_count_reg;
        new_bundle.sub_length = held_length_reg;
        new_bundle.end_type   = 8'd0;
        new_bundle.end_length = 8'd0;
        new_bundle.end_status = END_OK;

        unique case (phase_reg)
            PH_LEN:
            begin
                held_length_next      = option_bytes.data_byte;
                value_count_next      = 8'd0;
                new_bundle.sub_length = option_bytes.data_byte;
                if (option_bytes.data_byte == 8'd0)
                begin
                    new_mask[RES_COMMIT] = 1'b1;
                    phase_next           = PH_TYPE;
                end
                else
                begin
                    phase_next            = PH_VAL;
                    new_bundle.end_type   = held_type_reg;
                    new_bundle.end_length = option_bytes.data_byte;
                    new_bundle.end_status = END_TRUNC_VAL;
                end
            end
            PH_VAL:
            begin
                new_mask[RES_VALUE] = 1'b1;
                value_count_next    = count_inc;
                if (count_inc >= held_length_reg)
                begin
                    new_mask[RES_COMMIT] = 1'b1;
                    phase_next           = PH_TYPE;
                end
                else
                begin
                    new_bundle.end_type   = held_type_reg;
                    new_bundle.end_length = held_length_reg;
                    new_bundle.end_status = END_TRUNC_VAL;
                end
            end
            default:
            begin
                held_type_next        = option_bytes.data_byte;
                held_length_next      = 8'd0;
                value_count_next      = 8'd0;
                phase_next            = PH_LEN;
                new_bundle.end_type   = option_bytes.data_byte;
                new_bundle.end_status = END_TRUNC_HDR;
            end
        endcase

        if (option_bytes.last_byte)
        begin
            new_mask[RES_END] = 1'b1;
            phase_next        = PH_TYPE;
            held_type_next    = 8'd0;
            held_length_next  = 8'd0;
            value_count_next  = 8'd0;
        end

        if (!accept)
        begin
            phase_next       = phase_reg;
            held_type_next   = held_type_reg;
            held_length_next = held_length_reg;
            value_count_next = value_count_reg;
        end
    end

    // result buffer
    assign head_mask      = mask_reg[head_reg];
    assign head_bundle    = slot_reg[head_reg];
    assign low_bit        = head_mask & (~head_mask + 3'd1);
    assign head_mask_left = head_mask & ~low_bit;
    assign pop            = results.valid && results.ready;
    assign pop_done       = pop && (head_mask_left == 3'b000);
    assign push           = accept && (new_mask != 3'b000);
    assign tail           = head_reg ^ count_reg[0];

    always_comb
    begin
        mask_next[0] = mask_reg[0];
        mask_next[1] = mask_reg[1];
        head_next    = head_reg;
        count_next   = count_reg;
        if (pop)
        begin
            mask_next[head_reg] = head_mask_left;
        end
        if (pop_done)
        begin
            head_next = ~head_reg;
        end
        if (push)
        begin
            mask_next[tail] = new_mask;
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop_done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TYPE;
            held_type_reg   <= 8'd0;
            held_length_reg <= 8'd0;
            value_count_reg <= 8'd0;
            mask_reg[0]     <= 3'b000;
            mask_reg[1]     <= 3'b000;
            head_reg        <= 1'b0;
            count_reg       <= 2'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            value_count_reg <= value_count_next;
            mask_reg[0]     <= mask_next[0];
            mask_reg[1]     <= mask_next[1];
            head_reg        <= head_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail] <= new_bundle;
        end
    end

    // output word from the lowest pending result of the head slot
    always_comb
    begin
        results.valid      = (count_reg != 2'd0);
        results.run_last   = (head_mask_left == 3'b000);
        results.kind       = KIND_VALUE;
        results.sub_type   = head_bundle.sub_type;
        results.value_byte = 8'd0;
        results.byte_index = 8'd0;
        results.sub_length = head_bundle.sub_length;
        results.end_status = END_OK;
        if (low_bit[RES_VALUE])
        begin
            results.value_byte = head_bundle.value_byte;
            results.byte_index = head_bundle.byte_index;
        end
        else if (low_bit[RES_COMMIT])
        begin
            results.kind = KIND_COMMIT;
        end
        else
        begin
            results.kind       = KIND_END;
            results.sub_type   = head_bundle.end_type;
            results.sub_length = head_bundle.end_length;
            results.end_status = head_bundle.end_status;
        end
    end

    a_head_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd0) |-> (head_mask != 3'b000))
        else $error("buffered slot has no pending result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer overfilled");

    a_value_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VAL) |-> (held_length_reg != 8'd0
                                   && value_count_reg < held_length_reg))
        else $error("value phase with exhausted length");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && option_bytes.last_byte) |=>
            (phase_reg == PH_TYPE && value_count_reg == 8'd0
             && held_type_reg == 8'd0))
        else $error("parser not back at start after last byte");

endmodule

[tb/sv/relay_agent_suboption_parser_tb.sv]
module relay_agent_suboption_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rasp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } option_byte_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sub_type;
        logic [7:0] value_byte;
        logic [7:0] byte_index;
        logic [7:0] sub_length;
        logic [1:0] end_status;
        logic       run_last;
    } parse_word_t;

    logic clk;
    logic rst_n;

    rasp_in_if  option_bytes ();
    rasp_out_if results ();

    relay_agent_suboption_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .option_bytes (option_bytes),
        .results      (results)
    );

    option_byte_t pending_bytes[$];
    parse_word_t  expected_words[$];
    int           total_queued;
    int           mismatches;
    int           src_idle_pct;
    int           snk_idle_pct;

    // parser state mirror
    phase_t     cur_phase;
    logic [7:0] cur_type;
    logic [7:0] cur_length;
    logic [7:0] cur_count;

    function automatic parse_word_t make_word(logic [1:0] kind, logic [7:0] typ,
                                              logic [7:0] vb, logic [7:0] idx,
                                              logic [7:0] len, logic [1:0] st);
        parse_word_t w;
        w.kind       = kind;
        w.sub_type   = typ;
        w.value_byte = vb;
        w.byte_index = idx;
        w.sub_length = len;
        w.end_status = st;
        w.run_last   = 1'b0;
        return w;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        parse_word_t words[$];
        logic [1:0]  status;
        logic [7:0]  end_type;
        logic [7:0]  end_len;
        status   = END_OK;
        end_type = '0;
        end_len  = '0;
        case (cur_phase)
            PH_LEN:
            begin
                cur_length = b;
                cur_count  = '0;
                if (b == 8'd0)
                begin
                    words = {words, make_word(KIND_COMMIT, cur_type, 8'd0, 8'd0, 8'd0,
                                              END_OK)};
                    cur_phase = PH_TYPE;
                end
                else
                begin
                    cur_phase = PH_VAL;
                    if (last)
                    begin
                        status   = END_TRUNC_VAL;
                        end_type = cur_type;
                        end_len  = cur_length;
                    end
                end
            end
            PH_VAL:
            begin
                words = {words, make_word(KIND_VALUE, cur_type, b, cur_count, cur_length,
                                          END_OK)};
                cur_count = cur_count + 8'd1;
                if (cur_count >= cur_length)
                begin
                    words = {words, make_word(KIND_COMMIT, cur_type, 8'd0, 8'd0, cur_length,
                                              END_OK)};
                    cur_phase = PH_TYPE;
                end
                else if (last)
                begin
                    status   = END_TRUNC_VAL;
                    end_type = cur_type;
                    end_len  = cur_length;
                end
            end
            default:
            begin
                // type byte; an unused phase code is parsed as a type byte as well
                cur_type   = b;
                cur_length = '0;
                cur_count  = '0;
                cur_phase  = PH_LEN;
                if (last)
                begin
                    status   = END_TRUNC_HDR;
                    end_type = cur_type;
                end
            end
        endcase
        if (last)
        begin
            words = {words, make_word(KIND_END, end_type, 8'd0, 8'd0, end_len, status)};
            cur_phase  = PH_TYPE;
            cur_type   = '0;
            cur_length = '0;
            cur_count  = '0;
        end
        if (words.size() > 0)
            words[words.size() - 1].run_last = 1'b1;
        expected_words = {expected_words, words};
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic last);
        option_byte_t item;
        item.data = data;
        item.last = last;
        pending_bytes = {pending_bytes, item};
        total_queued++;
    endtask

    // one option: mostly well-formed sub-option runs, some cut short, some noise
    task automatic queue_option();
        option_byte_t bytes[$];
        option_byte_t item;
        int           n_sub;
        int           len;
        int           cut;
        int           pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
            begin
                item.data = 8'($urandom_range(255));
                item.last = 1'b0;
                bytes = {bytes, item};
            end
        end
        else
        begin
            n_sub = $urandom_range(4, 1);
            for (int s = 0; s < n_sub; s++)
            begin
                len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(6);
                item.last = 1'b0;
                item.data = 8'($urandom_range(255));
                bytes = {bytes, item};
                item.data = 8'(len);
                bytes = {bytes, item};
                for (int i = 0; i < len; i++)
                begin
                    item.data = 8'($urandom_range(255));
                    bytes = {bytes, item};
                end
            end
            if (pick < 30)
            begin
                cut = $urandom_range(bytes.size(), 1);
                while (bytes.size() > cut)
                    void'(bytes.pop_back());
            end
        end
        bytes[bytes.size() - 1].last = 1'b1;
        foreach (bytes[i])
            push_byte(bytes[i].data, bytes[i].last);
    endtask

    task automatic queue_random(input int n_items);
        int start;
        start = total_queued;
        while (total_queued - start < n_items)
            queue_option();
    endtask

    task automatic wait_drained();
        while (!(pending_bytes.size() == 0 && !option_bytes.valid
                 && expected_words.size() == 0))
            @(negedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            option_bytes.valid     <= 1'b0;
            option_bytes.data_byte <= '0;
            option_bytes.last_byte <= 1'b0;
        end
        else
        begin
            option_byte_t item;
            if (option_bytes.valid && option_bytes.ready)
                parse_byte(option_bytes.data_byte, option_bytes.last_byte);
            if (!option_bytes.valid || option_bytes.ready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    item = pending_bytes.pop_front();
                    option_bytes.valid     <= 1'b1;
                    option_bytes.data_byte <= item.data;
                    option_bytes.last_byte <= item.last;
                end
                else
                    option_bytes.valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            parse_word_t want;
            if (results.valid && results.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual kind %0h type %0h",
                             $time, results.kind, results.sub_type);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("kind", {6'd0, want.kind}, {6'd0, results.kind});
                    check_field("sub_type", want.sub_type, results.sub_type);
                    check_field("value_byte", want.value_byte, results.value_byte);
                    check_field("byte_index", want.byte_index, results.byte_index);
                    check_field("sub_length", want.sub_length, results.sub_length);
                    check_field("end_status", {6'd0, want.end_status},
                                {6'd0, results.end_status});
                    check_field("run_last", {7'd0, want.run_last}, {7'd0, results.run_last});
                end
            end
            results.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n                  = 1'b0;
        cur_phase              = PH_TYPE;
        cur_type               = '0;
        cur_length             = '0;
        cur_count              = '0;
        total_queued           = 0;
        mismatches             = 0;
        src_idle_pct           = 13;
        snk_idle_pct           = 58;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero-length sub-options, extreme types and value bytes
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h55, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'hAA, 1'b0);
        // repeated type, then clean end on the final value byte
        push_byte(8'h01, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h7E, 1'b0);
        push_byte(8'h02, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h33, 1'b1);
        // clean end on a zero length
        push_byte(8'h03, 1'b0); push_byte(8'h00, 1'b1);
        // end on a type byte
        push_byte(8'h09, 1'b1);
        // end on a nonzero length byte
        push_byte(8'h0A, 1'b0); push_byte(8'h05, 1'b1);
        // end inside the value
        push_byte(8'h0B, 1'b0); push_byte(8'h03, 1'b0);
        push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b1);
        push_byte(8'hFF, 1'b1);

        queue_random(40);
        wait_drained();

        @(negedge clk);
        src_idle_pct = 58;
        snk_idle_pct = 13;
        queue_random(25);
        // sender holds off until every word of the first half is out
        wait_drained();
        repeat (5) @(negedge clk);
        queue_random(25);
        wait_drained();

        @(negedge clk);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // longest sub-option (length 255) reaches byte index 254
        push_byte(8'hC3, 1'b0);
        push_byte(8'hFF, 1'b0);
        for (int i = 0; i < 255; i++)
            push_byte(8'($urandom_range(255)), 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
        queue_random(20);
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
